// File: rtl/tlbpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants of the page table translator
// Fixed field widths and the controller state encoding.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	// Fixed widths of the transaction fields
	localparam int ADDR_W  = 16;
	localparam int FRAME_W = 8;
	localparam int FREE_W  = 9;
	localparam int CNT_W   = 32;

	// Controller states, one-hot
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

endpackage
`default_nettype wire

// File: rtl/tlb_page_table_translator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_page_table_translator: logical to physical address translation
// A fully associative TLB with FIFO replacement in front of a page table
// memory that hands out frames in order on a page fault.
// ----------------------------------------------------------------------------
// For each translation, the accept edge registers the address and starts the
// synchronous page table read, and the next edge does the TLB compare, writes
// back the page table entry on a fault, refills the TLB slot named by the FIFO
// pointer on a miss and loads the result register. One translation is in
// flight at a time, so no new address is accepted until the result register
// is free. After reset the page table memory is swept clean, one entry per
// cycle, and no address is accepted during that sweep.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_BITS   = 8,
	parameter int OFFSET_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// address channel
	input  wire logic                             addr_valid,
	output logic                                  addr_ready,
	input  wire logic [tlbpt_pkg::ADDR_W-1:0]     logical_address,
	// translation channel
	output logic                                  xlat_valid,
	input  wire logic                             xlat_ready,
	output logic [tlbpt_pkg::ADDR_W-1:0]          physical_address,
	output logic [tlbpt_pkg::FRAME_W-1:0]         frame_number,
	output logic                                  tlb_hit,
	output logic                                  page_fault,
	output logic [tlbpt_pkg::CNT_W-1:0]           hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]           fault_total
);

	localparam int PAGE_COUNT = 1 << PAGE_BITS;
	localparam int PTR_W      = $clog2(TLB_ENTRIES);
	localparam int ENTRY_W    = tlbpt_pkg::FRAME_W + 1;

	tlbpt_pkg::state_t state_q;

	logic                            accept;
	logic [31:0]                     addr_ext;
	logic [31:0]                     addr_shift;
	logic [PAGE_BITS-1:0]            page_in;
	logic [PAGE_BITS-1:0]            page_s1;
	logic [OFFSET_BITS-1:0]          offset_s1;
	logic [PAGE_BITS-1:0]            clr_q;

	logic [ENTRY_W-1:0]              pt_mem [PAGE_COUNT];
	logic [ENTRY_W-1:0]              pt_rdata_s1;
	logic                            pt_we;
	logic [PAGE_BITS-1:0]            pt_waddr;
	logic [ENTRY_W-1:0]              pt_wdata;

	logic [TLB_ENTRIES-1:0]          tlb_valid_q;
	logic [PAGE_BITS-1:0]            tlb_page_q  [TLB_ENTRIES];
	logic [tlbpt_pkg::FRAME_W-1:0]   tlb_frame_q [TLB_ENTRIES];
	logic [PTR_W-1:0]                tlb_ptr_q;

	logic [tlbpt_pkg::FREE_W-1:0]    free_q;
	logic [tlbpt_pkg::CNT_W-1:0]     hit_cnt_q;
	logic [tlbpt_pkg::CNT_W-1:0]     fault_cnt_q;

	logic                            tlb_match;
	logic [tlbpt_pkg::FRAME_W-1:0]   tlb_match_frame;
	logic                            fault;
	logic [tlbpt_pkg::FRAME_W-1:0]   frame;
	logic [31:0]                     pa_wide;

	// Handshake: one transaction in flight, result register free by then
	assign addr_ready = (state_q == tlbpt_pkg::ST_IDLE) && (!xlat_valid || xlat_ready);
	assign accept     = addr_valid && addr_ready;

	// Page number from the bits above the offset, missing bits read as zero
	assign addr_ext   = {16'b0, logical_address};
	assign addr_shift = addr_ext >> OFFSET_BITS;
	assign page_in    = addr_shift[PAGE_BITS-1:0];

	// TLB compare, lowest matching slot wins
	always_comb begin
		tlb_match       = 1'b0;
		tlb_match_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && (tlb_page_q[i] == page_s1)) begin
				tlb_match       = 1'b1;
				tlb_match_frame = tlb_frame_q[i];
			end
		end
	end

	// Miss path: existing mapping or the next free frame
	assign fault = !tlb_match && !pt_rdata_s1[tlbpt_pkg::FRAME_W];
	always_comb begin
		if (tlb_match) begin
			frame = tlb_match_frame;
		end else if (pt_rdata_s1[tlbpt_pkg::FRAME_W]) begin
			frame = pt_rdata_s1[tlbpt_pkg::FRAME_W-1:0];
		end else begin
			frame = free_q[tlbpt_pkg::FRAME_W-1:0];
		end
	end

	assign pa_wide = (32'(frame) << OFFSET_BITS) | 32'(offset_s1);

	// Page table write port: clearing sweep or fault write-back
	always_comb begin
		if (state_q == tlbpt_pkg::ST_CLEAR) begin
			pt_we    = 1'b1;
			pt_waddr = clr_q;
			pt_wdata = '0;
		end else begin
			pt_we    = (state_q == tlbpt_pkg::ST_LOOK) && fault;
			pt_waddr = page_s1;
			pt_wdata = {1'b1, free_q[tlbpt_pkg::FRAME_W-1:0]};
		end
	end

	// Page table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		if (accept) begin
			pt_rdata_s1 <= pt_mem[page_in];
		end
	end

	// Address stage and TLB contents (payload, no reset)
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1   <= page_in;
			offset_s1 <= logical_address[OFFSET_BITS-1:0];
		end
		if ((state_q == tlbpt_pkg::ST_LOOK) && !tlb_match) begin
			tlb_page_q[tlb_ptr_q]  <= page_s1;
			tlb_frame_q[tlb_ptr_q] <= frame;
		end
		if (state_q == tlbpt_pkg::ST_LOOK) begin
			physical_address <= pa_wide[tlbpt_pkg::ADDR_W-1:0];
			frame_number     <= frame;
			tlb_hit          <= tlb_match;
			page_fault       <= fault;
		end
	end

	// Control state, counters and TLB bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlbpt_pkg::ST_CLEAR;
			clr_q       <= '0;
			tlb_valid_q <= '0;
			tlb_ptr_q   <= '0;
			free_q      <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			xlat_valid  <= 1'b0;
		end else begin
			// result valid: set when the lookup finishes, cleared when taken
			if (state_q == tlbpt_pkg::ST_LOOK) begin
				xlat_valid <= 1'b1;
			end else if (xlat_ready) begin
				xlat_valid <= 1'b0;
			end
			case (state_q)
				tlbpt_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= tlbpt_pkg::ST_IDLE;
					end
				end
				tlbpt_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= tlbpt_pkg::ST_LOOK;
					end
				end
				tlbpt_pkg::ST_LOOK: begin
					state_q <= tlbpt_pkg::ST_IDLE;
					if (tlb_match) begin
						hit_cnt_q <= hit_cnt_q + 1'b1;
					end else begin
						tlb_valid_q[tlb_ptr_q] <= 1'b1;
						if (tlb_ptr_q == PTR_W'(TLB_ENTRIES - 1)) begin
							tlb_ptr_q <= '0;
						end else begin
							tlb_ptr_q <= tlb_ptr_q + 1'b1;
						end
					end
					if (fault) begin
						free_q      <= free_q + 1'b1;
						fault_cnt_q <= fault_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= tlbpt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Counters change only when a result loads, so they serve as its totals
	assign hit_total   = hit_cnt_q;
	assign fault_total = fault_cnt_q;

`ifndef NO_ASSERTIONS
	// No address taken while the page table is being swept
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlbpt_pkg::ST_CLEAR) |-> !addr_ready)
		else $error("address accepted during page table sweep");

	// An accepted address yields a result once its lookup finishes
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 xlat_valid)
		else $error("translation result missing");

	// A TLB hit never reports a fault
	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		xlat_valid |-> !(tlb_hit && page_fault))
		else $error("hit and fault reported together");

	// A fault advances the fault count by one
	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tlbpt_pkg::ST_LOOK) && fault) |=>
		(fault_cnt_q == $past(fault_cnt_q) + 1'b1))
		else $error("fault count did not advance");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tlb_page_table_translator
// Streams logical addresses through the translator and checks each
// translation against a cycle-free model of the TLB, its FIFO refill pointer,
// the page table and the frame allocator. The run walks through phases of
// source idling and sink stalling, including one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int TLB_SLOTS   = 16;
	localparam int PAGES       = 256;
	localparam int WORK_PAGES  = 20;
	localparam int HOLD_CYCLES = 120;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 12;

	typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

	typedef struct packed {
		logic [tlbpt_pkg::ADDR_W-1:0]  phys;
		logic [tlbpt_pkg::FRAME_W-1:0] frame;
		logic                          hit;
		logic                          fault;
		logic [tlbpt_pkg::CNT_W-1:0]   hits;
		logic [tlbpt_pkg::CNT_W-1:0]   faults;
	} xlat_t;

	logic                           clk;
	logic                           arst_n;
	logic                           addr_valid;
	logic                           addr_ready;
	logic [tlbpt_pkg::ADDR_W-1:0]   logical_address;
	logic                           xlat_valid;
	logic                           xlat_ready;
	logic [tlbpt_pkg::ADDR_W-1:0]   physical_address;
	logic [tlbpt_pkg::FRAME_W-1:0]  frame_number;
	logic                           tlb_hit;
	logic                           page_fault;
	logic [tlbpt_pkg::CNT_W-1:0]    hit_total;
	logic [tlbpt_pkg::CNT_W-1:0]    fault_total;

	phase_t                         phase = PH_FREE;
	logic [tlbpt_pkg::ADDR_W-1:0]   addr_pending[$];
	xlat_t                          xlat_expected[$];
	int                             err_count = 0;

	// model state: TLB, FIFO pointer, page table, allocator, counters
	bit                             tlb_used[TLB_SLOTS];
	logic [7:0]                     tlb_pg[TLB_SLOTS];
	logic [7:0]                     tlb_fr[TLB_SLOTS];
	int unsigned                    fifo_slot = 0;
	bit                             pg_mapped[PAGES];
	logic [7:0]                     pg_fr[PAGES];
	logic [tlbpt_pkg::FREE_W-1:0]   free_frame = '0;
	logic [tlbpt_pkg::CNT_W-1:0]    hit_cnt = '0;
	logic [tlbpt_pkg::CNT_W-1:0]    fault_cnt = '0;

	// stimulus shaping
	logic [7:0]                     work_set[WORK_PAGES];

	tlb_page_table_translator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.addr_valid       (addr_valid),
		.addr_ready       (addr_ready),
		.logical_address  (logical_address),
		.xlat_valid       (xlat_valid),
		.xlat_ready       (xlat_ready),
		.physical_address (physical_address),
		.frame_number     (frame_number),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault),
		.hit_total        (hit_total),
		.fault_total      (fault_total)
	);

	// Translate one address and advance the model state
	function automatic xlat_t translate_address(logic [tlbpt_pkg::ADDR_W-1:0] addr);
		logic [7:0] page;
		logic [7:0] frame;
		bit         hit;
		bit         fault;
		xlat_t      res;
		page  = addr[15:8];
		frame = '0;
		hit   = 0;
		fault = 0;
		// lowest matching slot wins
		for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
			if (tlb_used[i] && tlb_pg[i] == page) begin
				hit   = 1;
				frame = tlb_fr[i];
			end
		end
		if (hit) begin
			hit_cnt = hit_cnt + 1;
		end else begin
			// page fault: hand out the next frame, allocator wraps at 512
			if (!pg_mapped[page]) begin
				pg_fr[page]     = free_frame[7:0];
				pg_mapped[page] = 1;
				free_frame      = free_frame + 1'b1;
				fault_cnt       = fault_cnt + 1;
				fault           = 1;
			end
			frame               = pg_fr[page];
			tlb_pg[fifo_slot]   = page;
			tlb_fr[fifo_slot]   = frame;
			tlb_used[fifo_slot] = 1;
			fifo_slot           = (fifo_slot + 1) % TLB_SLOTS;
		end
		res.phys   = {frame, addr[7:0]};
		res.frame  = frame;
		res.hit    = hit;
		res.fault  = fault;
		res.hits   = hit_cnt;
		res.faults = fault_cnt;
		return res;
	endfunction

	function automatic int src_idle_pct(phase_t ph);
		case (ph)
			PH_SRC_IDLE: return 73;
			PH_BOTH:     return 33;
			default:     return 0;
		endcase
	endfunction

	function automatic int snk_stall_pct(phase_t ph);
		case (ph)
			PH_SNK_STALL: return 73;
			PH_BOTH:      return 33;
			default:      return 0;
		endcase
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Addresses with locality: mostly a drifting working set near TLB size
	task automatic queue_random(int count);
		logic [7:0] page;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 6)
				work_set[$urandom_range(0, WORK_PAGES - 1)] =
					8'($urandom_range(0, PAGES - 1));
			if ($urandom_range(0, 99) < 65)
				page = work_set[$urandom_range(0, WORK_PAGES - 1)];
			else
				page = 8'($urandom_range(0, PAGES - 1));
			addr_pending.push_back({page, 8'($urandom_range(0, 255))});
		end
	endtask

	// Touch every page once in shuffled order so the allocator reaches frame 255
	task automatic queue_sweep();
		int order[PAGES];
		int j;
		int t;
		for (int i = 0; i < PAGES; i++)
			order[i] = i;
		for (int i = PAGES - 1; i > 0; i--) begin
			j        = int'($urandom_range(0, i));
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < PAGES; i++)
			addr_pending.push_back({8'(order[i]), 8'($urandom_range(0, 255))});
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (addr_pending.size() != 0 || addr_valid || xlat_expected.size() != 0);
	endtask

	// Clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Source side: present queued addresses, hold until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_valid      <= 0;
			logical_address <= '0;
		end else if (!addr_valid || addr_ready) begin
			if (addr_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct(phase)) begin
				addr_valid      <= 1;
				logical_address <= addr_pending.pop_front();
			end else begin
				addr_valid <= 0;
			end
		end
	end

	// Sink side: check results, then record the newly accepted address
	int  rx_seen;
	int  hold_left;
	bit  hold_done;
	always @(posedge clk or negedge arst_n) begin
		xlat_t want;
		if (!arst_n) begin
			xlat_ready <= 0;
			rx_seen    <= 0;
			hold_left  <= 0;
			hold_done  <= 0;
		end else begin
			if (xlat_valid && xlat_ready) begin
				rx_seen <= rx_seen + 1;
				if (xlat_expected.size() == 0) begin
					$display("%0t: unexpected transaction, expected none actual phys %h",
						$time, physical_address);
					err_count++;
				end else begin
					want = xlat_expected.pop_front();
					check_field("physical_address", want.phys, physical_address);
					check_field("frame_number", want.frame, frame_number);
					check_field("tlb_hit", want.hit, tlb_hit);
					check_field("page_fault", want.fault, page_fault);
					check_field("hit_total", want.hits, hit_total);
					check_field("fault_total", want.faults, fault_total);
				end
			end
			if (addr_valid && addr_ready)
				xlat_expected.push_back(translate_address(logical_address));
			// one long hold-off while the source keeps pushing
			if (hold_left > 0) begin
				xlat_ready <= 0;
				hold_left  <= hold_left - 1;
			end else if (phase == PH_FREE && !hold_done && rx_seen == 40) begin
				xlat_ready <= 0;
				hold_done  <= 1;
				hold_left  <= HOLD_CYCLES;
			end else begin
				xlat_ready <= ($urandom_range(0, 99) >= snk_stall_pct(phase));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((addr_valid && addr_ready) || (xlat_valid && xlat_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Reset, then the stimulus phases
	initial begin
		for (int i = 0; i < WORK_PAGES; i++)
			work_set[i] = 8'($urandom_range(0, PAGES - 1));
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: address extremes, page 255 / frame reuse by hit,
		// FIFO wrap evicting early pages, miss that finds a mapped page
		phase = PH_FREE;
		addr_pending.push_back(16'h0000);
		addr_pending.push_back(16'h00FF);
		addr_pending.push_back(16'hFFFF);
		addr_pending.push_back(16'hFF00);
		addr_pending.push_back(16'h8000);
		addr_pending.push_back(16'h7FFF);
		addr_pending.push_back(16'h5AA5);
		addr_pending.push_back(16'hA55A);
		for (int p = 1; p <= 14; p++)
			addr_pending.push_back({8'(p), 8'(p * 17)});
		addr_pending.push_back(16'h0042);
		addr_pending.push_back(16'hFF11);
		queue_random(200);
		wait_drained();

		phase = PH_SRC_IDLE;
		queue_sweep();
		queue_random(50);
		wait_drained();

		phase = PH_SNK_STALL;
		queue_random(260);
		wait_drained();

		phase = PH_BOTH;
		queue_random(260);
		wait_drained();

		phase = PH_FREE;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0 && xlat_expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: tlb_page_table_translator.f
rtl/tlbpt_pkg.sv
rtl/tlb_page_table_translator.sv
bench/tb.sv
